// ===== hw/rtl/dst_pkg.sv =====
// descriptor slot table package: payload structs, operation and status codes,
// controller/datapath command and status structs, default sizes
// no dependencies
package dst_pkg;

  localparam int SLOT_COUNT_DEF = 128;
  localparam int FD_BASE_DEF    = 3;

  // free search groups the used marks into words of this size
  localparam int GRP_SIZE = 16;
  localparam int GRP_W    = 4;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] kernel_handle;
    logic [15:0] user_fd;
  } dst_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fd_out;
    logic [30:0] handle_out;
  } dst_rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic check;
  } dst_cmd_t;

  typedef struct packed {
    logic req_alloc;
  } dst_sts_t;

endpackage

// ===== hw/rtl/dst_ctrl.sv =====
// descriptor slot table controller: sequences allocate and lookup/release beats
// depends on dst_pkg
module dst_ctrl
  import dst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dst_sts_t sts,
  output dst_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PICK  = 5'b00100,
    S_CHECK = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = !(state == S_IDLE || state == S_RESP);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE, S_RESP: begin
        if (accept) begin
          state_next = sts.req_alloc ? S_SCAN : S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN:  state_next = S_PICK;
      S_PICK:  state_next = S_RESP;
      S_CHECK: state_next = S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load   = accept;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_PICK);
  assign cmd.check  = (state == S_CHECK);

endmodule

// ===== hw/rtl/dst_datapath.sv =====
// descriptor slot table datapath: used marks, handle memory, two-level
// first-free search, range check and result register
// depends on dst_pkg
module dst_datapath
  import dst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int FD_BASE    = FD_BASE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dst_req_t req,
  input  dst_cmd_t cmd,
  output dst_sts_t sts,
  output dst_rsp_t rsp
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NGRP   = (SLOT_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SCAN_W = GIDX_W + GRP_W;

  dst_req_t                req_q;
  logic [SLOT_COUNT-1:0]   used;
  logic [30:0]             mem [SLOT_COUNT];

  logic [NGRP*GRP_SIZE-1:0] used_pad;
  logic [NGRP-1:0]          grp_free_c;
  logic [GRP_W-1:0]         grp_loc_c [NGRP];
  logic [NGRP-1:0]          grp_free;
  logic [GRP_W-1:0]         grp_loc [NGRP];

  logic                     pick_any;
  logic [GIDX_W-1:0]        pick_g;
  logic [SCAN_W-1:0]        pick_slot;
  logic [IDX_W-1:0]         pick_idx;

  logic [16:0]              diff;
  logic                     below;
  logic                     beyond;
  logic                     is_lr;
  logic                     hit;
  logic [IDX_W-1:0]         chk_idx;

  assign sts.req_alloc = (req.func == OP_ALLOC);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // first level: lowest free bit inside each group
  always_comb begin
    used_pad = '1;
    used_pad[SLOT_COUNT-1:0] = used;
    for (int g = 0; g < NGRP; g++) begin
      grp_free_c[g] = ~&used_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_loc_c[g]  = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!used_pad[g*GRP_SIZE + b]) begin
          grp_loc_c[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      grp_free <= grp_free_c;
      grp_loc  <= grp_loc_c;
    end
  end

  // second level: lowest group with a free slot
  always_comb begin
    pick_any = 1'b0;
    pick_g   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        pick_any = 1'b1;
        pick_g   = GIDX_W'(g);
      end
    end
    pick_slot = {pick_g, grp_loc[pick_g]};
    pick_idx  = IDX_W'(pick_slot);
  end

  always_comb begin
    diff    = {1'b0, req_q.user_fd} - 17'(FD_BASE);
    below   = (req_q.user_fd < 16'(FD_BASE));
    beyond  = (diff >= 17'(SLOT_COUNT));
    chk_idx = diff[IDX_W-1:0];
    is_lr   = (req_q.func == OP_LOOKUP) || (req_q.func == OP_RELEASE);
    hit     = is_lr && !below && !beyond && used[chk_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit && pick_any) begin
      used[pick_idx] <= 1'b1;
    end else if (cmd.check && hit && (req_q.func == OP_RELEASE)) begin
      used[chk_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && pick_any) begin
      mem[pick_idx] <= req_q.kernel_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.handle_out <= '0;
      if (pick_any) begin
        rsp.status <= ST_OK;
        rsp.fd_out <= 16'(pick_slot) + 16'(FD_BASE);
      end else begin
        rsp.status <= ST_FULL;
        rsp.fd_out <= '0;
      end
    end else if (cmd.check) begin
      rsp.fd_out <= '0;
      if (hit) begin
        rsp.status     <= ST_OK;
        rsp.handle_out <= mem[chk_idx];
      end else begin
        rsp.status     <= ST_BAD;
        rsp.handle_out <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/descriptor_slot_table.sv =====
// descriptor slot table top level: lowest-free slot allocator with lookup and release
// steps: allocate goes through group scan, group pick and result; lookup/release through check and result
// next beat taken in the cycle the result shows; busy holds off start until then
// the first-free search over the used marks is the two-stage part that lengthens allocate
// reset: synchronous, clears all used marks and the controller; no clearing pass
// done is a one-cycle strobe with rsp; the receiver cannot stall
module descriptor_slot_table
  import dst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int FD_BASE    = FD_BASE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dst_req_t req,
  output logic     busy,
  output logic     done,
  output dst_rsp_t rsp
);

  dst_cmd_t cmd;
  dst_sts_t sts;

  dst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dst_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .FD_BASE    (FD_BASE)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== hw/rtl/dst_checker.sv =====
// descriptor slot table port checker and its bind to the top level
// depends on dst_pkg
module dst_checker
  import dst_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input dst_rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == ST_FULL) |-> (rsp.fd_out == '0) && (rsp.handle_out == '0))
    else $error("table full result carries data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("block not idle after reset");

endmodule

bind descriptor_slot_table dst_checker u_dst_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ===== tb/descriptor_slot_table_test.sv =====
`timescale 1ns / 1ps
// testbench for descriptor_slot_table: directed and random allocate/lookup/release beats,
// each result checked against a behavioral copy of the slot marks and handles
// depends on dst_pkg and descriptor_slot_table
module descriptor_slot_table_test;
  import dst_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int BASE  = FD_BASE_DEF;
  localparam int RANDOM_BEATS = 1665;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic     clk;
  logic     rst;
  logic     start;
  dst_req_t req;
  logic     busy;
  logic     done;
  dst_rsp_t rsp;

  logic        slot_in_use [SLOTS];
  logic [30:0] slot_value [SLOTS];
  dst_rsp_t    pending_replies [$];
  int          error_count;
  int          burst_left;

  descriptor_slot_table DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      slot_in_use[i] = 1'b0;
      slot_value[i]  = '0;
    end
  endfunction

  function automatic dst_rsp_t predict_slot_op(dst_req_t r);
    dst_rsp_t o;
    int slot;
    o = '0;
    o.status = ST_BAD;
    if (r.func == OP_ALLOC) begin
      o.status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_in_use[i]) begin
          slot_in_use[i] = 1'b1;
          slot_value[i]  = r.kernel_handle;
          o.fd_out = 16'(i + BASE);
          o.status = ST_OK;
          break;
        end
      end
    end else if (r.func == OP_LOOKUP || r.func == OP_RELEASE) begin
      slot = int'(r.user_fd) - BASE;
      if (slot >= 0 && slot < SLOTS && slot_in_use[slot]) begin
        o.handle_out = slot_value[slot];
        o.status = ST_OK;
        if (r.func == OP_RELEASE) begin
          slot_in_use[slot] = 1'b0;
          slot_value[slot]  = '0;
        end
      end
    end
    return o;
  endfunction

  function automatic dst_req_t make_req(logic [1:0] f, logic [30:0] h, logic [15:0] fd);
    dst_req_t r;
    r.func = f;
    r.kernel_handle = h;
    r.user_fd = fd;
    return r;
  endfunction

  function automatic logic [30:0] random_handle();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return 31'($urandom);
  endfunction

  // descriptor of some slot in use, or any in-range descriptor when none is
  function automatic logic [15:0] used_fd();
    int first;
    int idx;
    first = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      idx = (first + i) % SLOTS;
      if (slot_in_use[idx]) return 16'(idx + BASE);
    end
    return 16'(first + BASE);
  endfunction

  // sender bursts and gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_beat(dst_req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_slot_op(r));
    pace_sender();
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    dst_rsp_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result beat: status %0d fd_out %0d handle_out %0h",
               rsp.status, rsp.fd_out, rsp.handle_out);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.fd_out !== want.fd_out) begin
          $error("fd_out: expected %0d, got %0d", want.fd_out, rsp.fd_out);
          error_count++;
        end
        if (rsp.handle_out !== want.handle_out) begin
          $error("handle_out: expected %0h, got %0h", want.handle_out, rsp.handle_out);
          error_count++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_beat(make_req(OP_ALLOC, 31'h0, 16'hFFFF));
    send_beat(make_req(OP_ALLOC, 31'h7FFF_FFFF, 16'h0000));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'(BASE)));
    send_beat(make_req(OP_LOOKUP, 31'h7FFF_FFFF, 16'(BASE)));
    send_beat(make_req(OP_LOOKUP, 31'h0, 16'(BASE + 1)));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'd0));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'd1));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE - 1)));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'(BASE + SLOTS)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'hFFFF));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'(BASE + SLOTS - 1)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + 1)));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'(BASE + 1)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + 1)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'hA5A5));
    send_beat(make_req(OP_UNKNOWN, 31'h7FFF_FFFF, 16'(BASE)));
    send_beat(make_req(OP_UNKNOWN, 31'h0, 16'hFFFF));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + 1)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + 2)));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'(BASE)));
    drain_replies();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++) send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    send_beat(make_req(OP_LOOKUP, random_handle(), 16'(BASE + SLOTS - 1)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + SLOTS - 1)));
    send_beat(make_req(OP_RELEASE, random_handle(), 16'(BASE + 50)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    send_beat(make_req(OP_ALLOC, random_handle(), 16'($urandom)));
    drain_replies();
    for (int i = 0; i < SLOTS; i++)
      send_beat(make_req(OP_RELEASE, random_handle(), 16'(SLOTS - 1 - i + BASE)));
    drain_replies();
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_left;
    int alloc_weight;
    int roll;
    logic [1:0]  f;
    logic [15:0] fd;
    sent = 0;
    phase_left = 0;
    alloc_weight = 50;
    while (sent < RANDOM_BEATS) begin
      if (phase_left == 0) begin
        case ($urandom_range(4))
          0: alloc_weight = 10;
          1: alloc_weight = 35;
          2: alloc_weight = 50;
          3: alloc_weight = 75;
          default: alloc_weight = 95;
        endcase
        phase_left = $urandom_range(40, 250);
        if ($urandom_range(2) == 0) drain_replies();
      end
      roll = $urandom_range(99);
      if (roll < 2) begin
        f = OP_UNKNOWN;
        fd = 16'($urandom);
      end else if (roll < alloc_weight) begin
        f = OP_ALLOC;
        fd = 16'($urandom);
      end else begin
        f = ($urandom_range(1) == 0) ? OP_LOOKUP : OP_RELEASE;
        roll = $urandom_range(99);
        if (roll < 80)      fd = used_fd();
        else if (roll < 90) fd = 16'($urandom_range(BASE + SLOTS - 1, BASE));
        else if (roll < 95) fd = 16'($urandom);
        else if (roll < 98) fd = 16'($urandom_range(BASE - 1, 0));
        else                fd = 16'($urandom_range(BASE + SLOTS + 1, BASE + SLOTS));
      end
      send_beat(make_req(f, random_handle(), fd));
      sent++;
      phase_left--;
    end
    drain_replies();
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    error_count = 0;
    burst_left = 0;
    clear_slots();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_table_full();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
